// ===== hw/rtl/clex_pkg.sv =====
package clex_pkg;

  localparam int unsigned LineBits = 16;
  localparam int unsigned LenBits = 7;
  localparam int unsigned KindBits = 5;
  localparam int unsigned NumKw = 9;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrBits = $clog2(QDepth);
  localparam int unsigned QCntBits = $clog2(QDepth + 1);

  localparam logic [LenBits-1:0] MaxWordLength = LenBits'(127);
  localparam logic [LineBits-1:0] LineMax = '1;
  localparam logic [NumKw-1:0] MaskAll = '1;

  // token kinds
  localparam logic [KindBits-1:0] TokIdent      = KindBits'(0);
  localparam logic [KindBits-1:0] TokNumber     = KindBits'(1);
  localparam logic [KindBits-1:0] TokKwBase     = KindBits'(2);
  localparam logic [KindBits-1:0] TokLParen     = KindBits'(11);
  localparam logic [KindBits-1:0] TokRParen     = KindBits'(12);
  localparam logic [KindBits-1:0] TokLBrace     = KindBits'(13);
  localparam logic [KindBits-1:0] TokRBrace     = KindBits'(14);
  localparam logic [KindBits-1:0] TokLBrack     = KindBits'(15);
  localparam logic [KindBits-1:0] TokRBrack     = KindBits'(16);
  localparam logic [KindBits-1:0] TokComma      = KindBits'(17);
  localparam logic [KindBits-1:0] TokSemi       = KindBits'(18);
  localparam logic [KindBits-1:0] TokAssign     = KindBits'(19);
  localparam logic [KindBits-1:0] TokMinus      = KindBits'(20);
  localparam logic [KindBits-1:0] TokDec        = KindBits'(21);
  localparam logic [KindBits-1:0] TokPlus       = KindBits'(22);
  localparam logic [KindBits-1:0] TokInc        = KindBits'(23);
  localparam logic [KindBits-1:0] TokLess       = KindBits'(24);
  localparam logic [KindBits-1:0] TokLineCom    = KindBits'(25);
  localparam logic [KindBits-1:0] TokBlockOpen  = KindBits'(26);
  localparam logic [KindBits-1:0] TokBlockClose = KindBits'(27);

  localparam logic [7:0] ChNewline = 8'h0A;

  typedef enum logic [3:0] {
    ModeIdle    = 4'd0,
    ModeIdent   = 4'd1,
    ModeNumber  = 4'd2,
    ModeMinus   = 4'd3,
    ModePlus    = 4'd4,
    ModeSlash   = 4'd5,
    ModeLineCom = 4'd6,
    ModeBlock   = 4'd7,
    ModeStar    = 4'd8
  } mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [KindBits-1:0] token_kind;
    logic [LineBits-1:0] token_line;
    logic [LenBits-1:0]  token_length;
    logic                last_of_run;
  } out_t;

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] len;
    len = 3'd0;
    unique case (k)
      4'd0: len = 3'd4;
      4'd1: len = 3'd3;
      4'd2: len = 3'd5;
      4'd3: len = 3'd4;
      4'd4: len = 3'd3;
      4'd5: len = 3'd5;
      4'd6: len = 3'd2;
      4'd7: len = 3'd4;
      4'd8: len = 3'd6;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // keyword character at a position, zero past the end of the keyword
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [LenBits-1:0] pos);
    logic [47:0] txt;
    logic [2:0]  len;
    logic [2:0]  idx;
    txt = '0;
    len = kw_len(k);
    unique case (k)
      4'd0: txt = 48'("void");
      4'd1: txt = 48'("int");
      4'd2: txt = 48'("float");
      4'd3: txt = 48'("char");
      4'd4: txt = 48'("for");
      4'd5: txt = 48'("while");
      4'd6: txt = 48'("if");
      4'd7: txt = 48'("else");
      4'd8: txt = 48'("return");
      default: txt = '0;
    endcase
    idx = len - 3'd1 - pos[2:0];
    if (pos >= LenBits'(len)) begin
      return 8'd0;
    end
    return txt[idx*8 +: 8];
  endfunction

endpackage

// ===== hw/rtl/c_subset_lexer.sv =====
// Byte-serial lexer for a small C subset. One source byte (or an end-of-text
// mark) is taken per cycle into an input register, decoded combinationally
// against the scan state, and its zero, one or two tokens are written into a
// four-entry result queue that drains one token per cycle while unstalled. A
// steady stream runs at one byte per clock if unstalled; a byte that closes a
// word and also forms a symbol yields two tokens and can hold the input while
// the queue drains. in_stall_o depends only on registered state. Tokens carry
// kind, line and length; last_of_run marks the final token of a byte.
module c_subset_lexer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  clex_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output clex_pkg::out_t out_data_o
);

  // input register
  logic          in_valid_q, in_valid_d;
  clex_pkg::in_t in_q;
  logic          in_accept, proc;

  // scan state
  clex_pkg::mode_e               mode_q, mode_d;
  logic [clex_pkg::LineBits-1:0] line_q, line_d;
  logic [clex_pkg::LenBits-1:0]  len_q, len_d;
  logic [clex_pkg::NumKw-1:0]    mask_q, mask_d;

  // result queue
  clex_pkg::out_t                mem_q [clex_pkg::QDepth];
  logic [clex_pkg::QPtrBits-1:0] head_q, head_d, tail_q, tail_d;
  logic [clex_pkg::QCntBits-1:0] cnt_q, cnt_d;
  logic                          pop;

  // decode
  logic [7:0]                    c;
  logic                          is_letter, is_digit;
  logic [clex_pkg::NumKw-1:0]    hit_cur, hit_first;
  logic [clex_pkg::KindBits-1:0] word_kind;
  logic [clex_pkg::LenBits-1:0]  len_inc;
  logic [clex_pkg::LineBits-1:0] line_inc;

  logic                          id_emit, id_nl;
  logic [clex_pkg::KindBits-1:0] id_kind;
  clex_pkg::mode_e               id_mode;

  logic                          a_v, use_idle;
  logic [clex_pkg::KindBits-1:0] a_kind;
  logic [clex_pkg::LenBits-1:0]  a_len;
  clex_pkg::out_t                s0, s1;
  logic                          s0_v, s1_v;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign proc       = in_valid_q && (cnt_q <= clex_pkg::QCntBits'(clex_pkg::QDepth - 2));
  assign in_stall_o = in_valid_q && !proc;
  assign in_valid_d = in_accept ? 1'b1 : (proc ? 1'b0 : in_valid_q);

  assign c         = in_q.char_code;
  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  assign is_digit  = c >= "0" && c <= "9";
  assign len_inc   = (len_q < clex_pkg::MaxWordLength) ? len_q + 1'b1 : len_q;
  assign line_inc  = (line_q < clex_pkg::LineMax) ? line_q + 1'b1 : line_q;

  always_comb begin
    for (int k = 0; k < clex_pkg::NumKw; k++) begin
      hit_cur[k]   = clex_pkg::kw_char(4'(k), len_q) == c;
      hit_first[k] = clex_pkg::kw_char(4'(k), '0) == c;
    end
  end

  // lowest matching keyword of full length wins
  always_comb begin
    word_kind = clex_pkg::TokIdent;
    for (int k = clex_pkg::NumKw - 1; k >= 0; k--) begin
      if (mask_q[k] && len_q == clex_pkg::LenBits'(clex_pkg::kw_len(4'(k)))) begin
        word_kind = clex_pkg::TokKwBase + clex_pkg::KindBits'(k);
      end
    end
    if (mode_q == clex_pkg::ModeNumber) begin
      word_kind = clex_pkg::TokNumber;
    end
  end

  // what a byte does when seen from idle
  always_comb begin
    id_emit = 1'b0;
    id_kind = clex_pkg::TokIdent;
    id_mode = clex_pkg::ModeIdle;
    id_nl   = 1'b0;
    if (c == clex_pkg::ChNewline) begin
      id_nl = 1'b1;
    end else if (is_letter) begin
      id_mode = clex_pkg::ModeIdent;
    end else if (is_digit) begin
      id_mode = clex_pkg::ModeNumber;
    end else begin
      unique case (c)
        "(": begin id_emit = 1'b1; id_kind = clex_pkg::TokLParen; end
        ")": begin id_emit = 1'b1; id_kind = clex_pkg::TokRParen; end
        "{": begin id_emit = 1'b1; id_kind = clex_pkg::TokLBrace; end
        "}": begin id_emit = 1'b1; id_kind = clex_pkg::TokRBrace; end
        "[": begin id_emit = 1'b1; id_kind = clex_pkg::TokLBrack; end
        "]": begin id_emit = 1'b1; id_kind = clex_pkg::TokRBrack; end
        ",": begin id_emit = 1'b1; id_kind = clex_pkg::TokComma; end
        ";": begin id_emit = 1'b1; id_kind = clex_pkg::TokSemi; end
        "=": begin id_emit = 1'b1; id_kind = clex_pkg::TokAssign; end
        "<": begin id_emit = 1'b1; id_kind = clex_pkg::TokLess; end
        "-": id_mode = clex_pkg::ModeMinus;
        "+": id_mode = clex_pkg::ModePlus;
        "/": id_mode = clex_pkg::ModeSlash;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    len_d    = len_q;
    mask_d   = mask_q;
    a_v      = 1'b0;
    a_kind   = clex_pkg::TokIdent;
    a_len    = clex_pkg::LenBits'(1);
    use_idle = 1'b0;

    if (in_q.end_of_text) begin
      if (mode_q == clex_pkg::ModeIdent || mode_q == clex_pkg::ModeNumber) begin
        a_v    = 1'b1;
        a_kind = word_kind;
        a_len  = len_q;
      end else if (mode_q == clex_pkg::ModeMinus) begin
        a_v    = 1'b1;
        a_kind = clex_pkg::TokMinus;
      end else if (mode_q == clex_pkg::ModePlus) begin
        a_v    = 1'b1;
        a_kind = clex_pkg::TokPlus;
      end
      mode_d = clex_pkg::ModeIdle;
      line_d = clex_pkg::LineBits'(1);
      len_d  = '0;
      mask_d = clex_pkg::MaskAll;
    end else begin
      unique case (mode_q)
        clex_pkg::ModeIdent: begin
          if (is_letter || is_digit) begin
            mask_d = mask_q & hit_cur;
            len_d  = len_inc;
          end else begin
            a_v      = 1'b1;
            a_kind   = word_kind;
            a_len    = len_q;
            use_idle = 1'b1;
          end
        end
        clex_pkg::ModeNumber: begin
          if (is_digit) begin
            len_d = len_inc;
          end else begin
            a_v      = 1'b1;
            a_kind   = clex_pkg::TokNumber;
            a_len    = len_q;
            use_idle = 1'b1;
          end
        end
        clex_pkg::ModeMinus: begin
          a_v = 1'b1;
          if (c == "-") begin
            a_kind = clex_pkg::TokDec;
            a_len  = clex_pkg::LenBits'(2);
            mode_d = clex_pkg::ModeIdle;
          end else begin
            a_kind   = clex_pkg::TokMinus;
            use_idle = 1'b1;
          end
        end
        clex_pkg::ModePlus: begin
          a_v = 1'b1;
          if (c == "+") begin
            a_kind = clex_pkg::TokInc;
            a_len  = clex_pkg::LenBits'(2);
            mode_d = clex_pkg::ModeIdle;
          end else begin
            a_kind   = clex_pkg::TokPlus;
            use_idle = 1'b1;
          end
        end
        clex_pkg::ModeSlash: begin
          if (c == "/") begin
            a_v    = 1'b1;
            a_kind = clex_pkg::TokLineCom;
            a_len  = clex_pkg::LenBits'(2);
            mode_d = clex_pkg::ModeLineCom;
          end else if (c == "*") begin
            a_v    = 1'b1;
            a_kind = clex_pkg::TokBlockOpen;
            a_len  = clex_pkg::LenBits'(2);
            mode_d = clex_pkg::ModeBlock;
          end else begin
            // lone slash gives no token
            use_idle = 1'b1;
          end
        end
        clex_pkg::ModeLineCom: begin
          if (c == clex_pkg::ChNewline) begin
            line_d = line_inc;
            mode_d = clex_pkg::ModeIdle;
          end
        end
        clex_pkg::ModeBlock: begin
          if (c == clex_pkg::ChNewline) begin
            line_d = line_inc;
          end else if (c == "*") begin
            mode_d = clex_pkg::ModeStar;
          end
        end
        clex_pkg::ModeStar: begin
          if (c == "/") begin
            a_v    = 1'b1;
            a_kind = clex_pkg::TokBlockClose;
            a_len  = clex_pkg::LenBits'(2);
            mode_d = clex_pkg::ModeIdle;
          end else if (c == clex_pkg::ChNewline) begin
            line_d = line_inc;
            mode_d = clex_pkg::ModeBlock;
          end else if (c != "*") begin
            mode_d = clex_pkg::ModeBlock;
          end
        end
        default: use_idle = 1'b1;
      endcase

      if (use_idle) begin
        mode_d = id_mode;
        if (id_nl) begin
          line_d = line_inc;
        end
        if (is_letter) begin
          len_d  = clex_pkg::LenBits'(1);
          mask_d = hit_first;
        end else if (is_digit) begin
          len_d  = clex_pkg::LenBits'(1);
          mask_d = clex_pkg::MaskAll;
        end
      end
    end
  end

  // pack the tokens of this byte into one or two queue slots
  always_comb begin
    s0_v = a_v || (use_idle && id_emit);
    s1_v = a_v && use_idle && id_emit;
    s0.token_kind   = a_v ? a_kind : id_kind;
    s0.token_line   = line_q;
    s0.token_length = a_v ? a_len : clex_pkg::LenBits'(1);
    s0.last_of_run  = !s1_v;
    s1.token_kind   = id_kind;
    s1.token_line   = line_q;
    s1.token_length = clex_pkg::LenBits'(1);
    s1.last_of_run  = 1'b1;
  end

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[head_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (pop) begin
      head_d = head_q + 1'b1;
    end
    if (proc) begin
      tail_d = tail_q + clex_pkg::QPtrBits'(s0_v) + clex_pkg::QPtrBits'(s1_v);
      cnt_d  = cnt_q + clex_pkg::QCntBits'(s0_v) + clex_pkg::QCntBits'(s1_v);
    end
    if (pop) begin
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= clex_pkg::ModeIdle;
      line_q     <= clex_pkg::LineBits'(1);
      len_q      <= '0;
      mask_q     <= clex_pkg::MaskAll;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      if (proc) begin
        mode_q <= mode_d;
        line_q <= line_d;
        len_q  <= len_d;
        mask_q <= mask_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (proc && s0_v) begin
      mem_q[tail_q] <= s0;
    end
    if (proc && s1_v) begin
      mem_q[tail_q + 1'b1] <= s1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= clex_pkg::QCntBits'(clex_pkg::QDepth))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) line_q != '0)
    else $error("line count reached zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.end_of_text |=> line_q == clex_pkg::LineBits'(1) &&
                                 mode_q == clex_pkg::ModeIdle)
    else $error("end of text did not restore scan state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == clex_pkg::ModeIdent || mode_q == clex_pkg::ModeNumber) |-> len_q != '0)
    else $error("open word with zero length");

endmodule

// ===== sim/c_subset_lexer_test.sv =====
`timescale 1ns / 100ps

module c_subset_lexer_test;
  import clex_pkg::*;

  typedef struct {
    in_t                 item;
    bit                  typed;
    int                  n_tok;
    logic [KindBits-1:0] kind;
    logic [LineBits-1:0] line;
    logic [LenBits-1:0]  len;
  } row_t;

  localparam int WatchdogLimit = 2000;
  localparam int RandItems = 1200;
  localparam int QuietTail = 150;
  localparam int DrainCycles = 20;

  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [KindBits-1:0] KwIf = TokKwBase + 5'd6;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  bit   quiet;
  int   errors;
  int   idle_cycles;

  // lexer state as predicted
  mode_e               lx_mode;
  logic [LineBits-1:0] lx_line;
  logic [LenBits-1:0]  lx_len;
  logic [NumKw-1:0]    lx_mask;

  out_t step_toks[$];
  out_t token_q[$];
  in_t  stim_q[$];
  row_t dir_tbl[$];

  string kw_names[9] = '{"void", "int", "float", "char", "for", "while", "if", "else",
                         "return"};
  string sym_chars = "()[]{},;=<";

  c_subset_lexer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void lx_reset();
    lx_mode = ModeIdle;
    lx_line = LineBits'(1);
    lx_len  = '0;
    lx_mask = MaskAll;
  endfunction

  function automatic void next_line();
    if (lx_line != LineMax) begin
      lx_line = lx_line + 1'b1;
    end
  endfunction

  function automatic void grow();
    if (lx_len < MaxWordLength) begin
      lx_len = lx_len + 1'b1;
    end
  endfunction

  // drop every keyword that cannot hold c at the current position
  function automatic void kw_filter(input logic [7:0] c);
    for (int k = 0; k < NumKw; k++) begin
      if (lx_mask[k] && (lx_len >= kw_names[k].len() || kw_names[k][lx_len] != c)) begin
        lx_mask[k] = 1'b0;
      end
    end
  endfunction

  function automatic logic [KindBits-1:0] word_kind();
    if (lx_mode == ModeNumber) begin
      return TokNumber;
    end
    for (int k = 0; k < NumKw; k++) begin
      if (lx_mask[k] && lx_len == kw_names[k].len()) begin
        return TokKwBase + KindBits'(k);
      end
    end
    return TokIdent;
  endfunction

  function automatic void emit_tok(input logic [KindBits-1:0] kind,
                                   input logic [LenBits-1:0] len);
    out_t t;
    if (step_toks.size() >= 2) begin
      return;
    end
    t.token_kind   = kind;
    t.token_line   = lx_line;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void from_idle(input logic [7:0] c);
    lx_mode = ModeIdle;
    if (c == ChNewline) begin
      next_line();
    end else if (is_letter(c)) begin
      lx_mode = ModeIdent;
      lx_len  = '0;
      lx_mask = MaskAll;
      kw_filter(c);
      grow();
    end else if (is_digit(c)) begin
      lx_mode = ModeNumber;
      lx_len  = LenBits'(1);
      lx_mask = MaskAll;
    end else begin
      case (c)
        "(": emit_tok(TokLParen, 7'd1);
        ")": emit_tok(TokRParen, 7'd1);
        "{": emit_tok(TokLBrace, 7'd1);
        "}": emit_tok(TokRBrace, 7'd1);
        "[": emit_tok(TokLBrack, 7'd1);
        "]": emit_tok(TokRBrack, 7'd1);
        ",": emit_tok(TokComma, 7'd1);
        ";": emit_tok(TokSemi, 7'd1);
        "=": emit_tok(TokAssign, 7'd1);
        "<": emit_tok(TokLess, 7'd1);
        "-": lx_mode = ModeMinus;
        "+": lx_mode = ModePlus;
        "/": lx_mode = ModeSlash;
        default: ;
      endcase
    end
  endfunction

  // tokens caused by one item, left in step_toks
  function automatic void lex_step(input in_t it);
    logic [7:0] c;
    c = it.char_code;
    step_toks.delete();
    if (it.end_of_text) begin
      case (lx_mode)
        ModeIdent, ModeNumber: emit_tok(word_kind(), lx_len);
        ModeMinus: emit_tok(TokMinus, 7'd1);
        ModePlus: emit_tok(TokPlus, 7'd1);
        default: ;
      endcase
      lx_reset();
    end else begin
      case (lx_mode)
        ModeIdent: begin
          if (is_letter(c) || is_digit(c)) begin
            kw_filter(c);
            grow();
          end else begin
            emit_tok(word_kind(), lx_len);
            from_idle(c);
          end
        end
        ModeNumber: begin
          if (is_digit(c)) begin
            grow();
          end else begin
            emit_tok(TokNumber, lx_len);
            from_idle(c);
          end
        end
        ModeMinus: begin
          if (c == "-") begin
            emit_tok(TokDec, 7'd2);
            lx_mode = ModeIdle;
          end else begin
            emit_tok(TokMinus, 7'd1);
            from_idle(c);
          end
        end
        ModePlus: begin
          if (c == "+") begin
            emit_tok(TokInc, 7'd2);
            lx_mode = ModeIdle;
          end else begin
            emit_tok(TokPlus, 7'd1);
            from_idle(c);
          end
        end
        ModeSlash: begin
          if (c == "/") begin
            emit_tok(TokLineCom, 7'd2);
            lx_mode = ModeLineCom;
          end else if (c == "*") begin
            emit_tok(TokBlockOpen, 7'd2);
            lx_mode = ModeBlock;
          end else begin
            from_idle(c);
          end
        end
        ModeLineCom: begin
          if (c == ChNewline) begin
            next_line();
            lx_mode = ModeIdle;
          end
        end
        ModeBlock: begin
          if (c == ChNewline) begin
            next_line();
          end else if (c == "*") begin
            lx_mode = ModeStar;
          end
        end
        ModeStar: begin
          if (c == "/") begin
            emit_tok(TokBlockClose, 7'd2);
            lx_mode = ModeIdle;
          end else if (c == ChNewline) begin
            next_line();
            lx_mode = ModeBlock;
          end else if (c != "*") begin
            lx_mode = ModeBlock;
          end
        end
        default: from_idle(c);
      endcase
    end
    if (step_toks.size() > 0) begin
      step_toks[step_toks.size()-1].last_of_run = 1'b1;
    end
  endfunction

  function automatic row_t pred(input logic [7:0] c, input bit eot);
    row_t r;
    r.item.char_code   = c;
    r.item.end_of_text = eot;
    r.typed = 1'b0;
    r.n_tok = 0;
    r.kind  = '0;
    r.line  = '0;
    r.len   = '0;
    return r;
  endfunction

  // row whose token (at most one) is written out by hand
  function automatic row_t fixed(input logic [7:0] c, input bit eot, input int n,
                                 input logic [KindBits-1:0] kind,
                                 input logic [LineBits-1:0] line,
                                 input logic [LenBits-1:0] len);
    row_t r;
    r = pred(c, eot);
    r.typed = 1'b1;
    r.n_tok = n;
    r.kind  = kind;
    r.line  = line;
    r.len   = len;
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] c, input bit eot = 1'b0);
    in_t it;
    it.char_code   = c;
    it.end_of_text = eot;
    stim_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) begin
      return 8'("a" + r);
    end else if (r < 52) begin
      return 8'("A" + r - 26);
    end
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // one lexical fragment of random content, mostly well formed
  function automatic void gen_fragment();
    int         n;
    string      kw;
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(125, 140) : $urandom_range(0, 7);
        push_byte(rand_letter());
        repeat (n) push_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
      end
      3, 4: begin
        kw = kw_names[$urandom_range(0, NumKw - 1)];
        n = kw.len();
        // keyword, possibly truncated, possibly with a tail
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, kw.len() - 1);
        end
        for (int i = 0; i < n; i++) begin
          push_byte(kw[i]);
        end
        if ($urandom_range(0, 3) == 0) begin
          push_byte(($urandom_range(0, 1) == 0) ? rand_digit() : rand_letter());
        end
      end
      5: begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(126, 135) : $urandom_range(1, 6);
        repeat (n) push_byte(rand_digit());
      end
      6, 7: push_byte(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
      8: begin
        c = ($urandom_range(0, 1) == 0) ? "-" : "+";
        push_byte(c);
        case ($urandom_range(0, 2))
          0: push_byte(c);
          1: push_byte((c == "-") ? "+" : "-");
          default: ;
        endcase
      end
      10: begin
        push_byte("/");
        push_byte("/");
        repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(0, 255)));
        push_byte(ChNewline);
      end
      11: begin
        push_byte("/");
        push_byte("*");
        repeat ($urandom_range(0, 12)) begin
          case ($urandom_range(0, 3))
            0: push_byte("*");
            1: push_byte(ChNewline);
            2: push_byte("/");
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
        end
        push_byte("*");
        push_byte("/");
      end
      12: begin
        push_byte("/");
        push_byte(8'($urandom_range(0, 255)));
      end
      13: push_byte(8'($urandom_range(0, 255)));
      14: begin
        if ($urandom_range(0, 3) == 0) begin
          push_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          push_byte(ChSpace);
        end
      end
      default: begin
        case ($urandom_range(0, 3))
          0: push_byte(ChSpace);
          1: push_byte(ChTab);
          2: push_byte(ChCr);
          default: push_byte(ChNewline);
        endcase
      end
    endcase
  endfunction

  task automatic send(input row_t r);
    out_t t;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r.item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_step(r.item);
    if (r.typed) begin
      if (r.n_tok > 0) begin
        t.token_kind   = r.kind;
        t.token_line   = r.line;
        t.token_length = r.len;
        t.last_of_run  = 1'b1;
        token_q.push_back(t);
      end
    end else begin
      foreach (step_toks[i]) token_q.push_back(step_toks[i]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
  endtask

  function automatic void chk(input string name, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_tokens
    out_t exp_tok;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("unexpected token: kind %0d line %0d length %0d", out_data.token_kind,
               out_data.token_line, out_data.token_length);
        errors++;
      end else begin
        exp_tok = token_q.pop_front();
        chk("token_kind", exp_tok.token_kind, out_data.token_kind);
        chk("token_line", exp_tok.token_line, out_data.token_line);
        chk("token_length", exp_tok.token_length, out_data.token_length);
        chk("last_of_run", exp_tok.last_of_run, out_data.last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls in bursts, with calm stretches in between
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 60) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    quiet = 1'b0;
    lx_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    dir_tbl = '{
      fixed("(", 1'b0, 1, TokLParen, 16'd1, 7'd1),
      pred("i", 1'b0),
      pred("f", 1'b0),
      fixed(ChNewline, 1'b0, 1, KwIf, 16'd1, 7'd2),
      pred("9", 1'b0),
      pred("0", 1'b0),
      fixed("+", 1'b0, 1, TokNumber, 16'd2, 7'd2),
      fixed("+", 1'b0, 1, TokInc, 16'd2, 7'd2),
      pred("-", 1'b0),
      // lone minus, the next byte still counts
      fixed("x", 1'b0, 1, TokMinus, 16'd2, 7'd1),
      pred("=", 1'b0),
      pred("/", 1'b0),
      fixed("*", 1'b0, 1, TokBlockOpen, 16'd2, 7'd2),
      pred(ChNewline, 1'b0),
      pred("*", 1'b0),
      fixed("/", 1'b0, 1, TokBlockClose, 16'd3, 7'd2),
      pred("/", 1'b0),
      fixed("/", 1'b0, 1, TokLineCom, 16'd3, 7'd2),
      pred(8'hFF, 1'b0),
      pred(ChNewline, 1'b0),
      pred("/", 1'b0),
      // lone slash dropped, null byte ignored
      fixed(8'h00, 1'b0, 0, TokIdent, 16'd0, 7'd0),
      fixed(8'hFF, 1'b0, 0, TokIdent, 16'd0, 7'd0),
      pred("w", 1'b0),
      fixed(8'hAA, 1'b1, 1, TokIdent, 16'd4, 7'd1),
      pred("-", 1'b0),
      fixed(8'h55, 1'b1, 1, TokMinus, 16'd1, 7'd1),
      fixed(8'h00, 1'b1, 0, TokIdent, 16'd0, 7'd0)
    };
    foreach (dir_tbl[i]) send(dir_tbl[i]);
    drain();

    send(fixed("{", 1'b0, 1, TokLBrace, 16'd1, 7'd1));
    send(fixed(8'h00, 1'b1, 0, TokIdent, 16'd0, 7'd0));
    send(fixed("}", 1'b0, 1, TokRBrace, 16'd1, 7'd1));
    drain();

    while (stim_q.size() < RandItems) gen_fragment();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
    while (stim_q.size() > 0) begin
      if (stim_q.size() == QuietTail) begin
        quiet = 1'b1;
      end
      send(pred(stim_q[0].char_code, stim_q[0].end_of_text));
      void'(stim_q.pop_front());
    end
    in_valid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (token_q.size() != 0) begin
      $error("%0d expected tokens never arrived", token_q.size());
    end
    if (errors == 0 && token_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/clex_pkg.sv
hw/rtl/c_subset_lexer.sv
sim/c_subset_lexer_test.sv
